[hdl/wes_pkg.sv]
// Package for the 2-D wave-equation stencil block: sizes, register indexes,
// boundary modes, the structs shared by the top level, update pipeline and result queue.
// Depends on nothing.
package wes_pkg;

   localparam int MAX_COLS    = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int SAMPLE_BITS = 32;

   localparam int LINE_LEN = MAX_COLS + 2;
   localparam int COL_W    = $clog2(LINE_LEN);
   localparam int ROW_W    = $clog2(MAX_ROWS + 2);
   localparam int CUR_AW   = $clog2(2 * LINE_LEN);

   localparam int COEF_W     = 16;
   localparam int MODE_W     = 2;
   localparam int MASK_W     = 4;
   localparam int DIM_W      = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int EDGE_TOP    = 0;
   localparam int EDGE_BOTTOM = 1;
   localparam int EDGE_LEFT   = 2;
   localparam int EDGE_RIGHT  = 3;

   localparam int FRAC_W     = 16;
   localparam int ROUND_HALF = 1 << (FRAC_W - 1);
   localparam int LAP_W      = SAMPLE_BITS + 3;
   localparam int MAG_W      = SAMPLE_BITS + 2;
   localparam int PROD_W     = COEF_W + MAG_W;
   localparam int SUM_W      = SAMPLE_BITS + 5;

   // result queue depth, power of two
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_ROWS,
      CSR_COEF_COLS,
      CSR_BOUNDARY_MODE,
      CSR_EDGE_MASK,
      CSR_GRID_ROWS,
      CSR_GRID_COLS
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      BMODE_SUPPLIED,
      BMODE_ZERO,
      BMODE_COPY
   } bmode_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } edge_type;

   typedef struct packed {
      sample_type value;
      logic       last;
   } result_type;

   function automatic logic signed [LAP_W-1:0] lap_ext(input sample_type x);
      return {{(LAP_W-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
   endfunction

   function automatic logic [CUR_AW-1:0] cur_addr(input logic bank,
                                                  input logic [COL_W-1:0] col);
      logic [CUR_AW-1:0] base;
      base = bank ? CUR_AW'(LINE_LEN) : '0;
      return base + CUR_AW'(col);
   endfunction

endpackage

[hdl/wes_update.sv]
// Five-stage arithmetic for one stencil update: halo substitution and Laplacians,
// magnitude, coefficient multiply, rounding, sum and saturation. Uses wes_pkg.
module wes_update (
   input  logic                           clock,
   input  logic                           reset,
   input  wes_pkg::ctl_type               in_ctl,
   input  wes_pkg::edge_type              in_edge,
   input  logic [wes_pkg::MODE_W-1:0]     mode,
   input  logic [wes_pkg::COEF_W-1:0]     coef_rows,
   input  logic [wes_pkg::COEF_W-1:0]     coef_cols,
   input  wes_pkg::sample_type            up_value,
   input  wes_pkg::sample_type            down_value,
   input  wes_pkg::sample_type            centre_value,
   input  wes_pkg::sample_type            left_value,
   input  wes_pkg::sample_type            right_value,
   input  wes_pkg::sample_type            old_value,
   output wes_pkg::ctl_type               out_ctl,
   output wes_pkg::sample_type            out_value
);
   import wes_pkg::*;

   localparam sample_type SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   function automatic sample_type halo(input sample_type supplied,
                                       input sample_type centre,
                                       input logic on_edge,
                                       input logic [MODE_W-1:0] m);
      sample_type v;
      v = supplied;
      if (on_edge) begin
         case (m)
            BMODE_ZERO: v = '0;
            BMODE_COPY: v = centre;
            default:    v = supplied;
         endcase
      end
      return v;
   endfunction

   function automatic logic signed [SUM_W-1:0] sum_ext(input logic signed [LAP_W-1:0] x);
      return {{(SUM_W-LAP_W){x[LAP_W-1]}}, x};
   endfunction

   // stage A
   sample_type                u_s, d_s, l_s, r_s;
   logic signed [LAP_W-1:0]   twice_c;
   ctl_type                   a_ctl_ff;
   logic signed [LAP_W-1:0]   a_lap_r_ff, a_lap_c_ff, a_base_ff;
   // stage B
   logic signed [LAP_W-1:0]   abs_r, abs_c;
   ctl_type                   b_ctl_ff;
   logic                      b_neg_r_ff, b_neg_c_ff;
   logic [MAG_W-1:0]          b_mag_r_ff, b_mag_c_ff;
   logic signed [LAP_W-1:0]   b_base_ff;
   // stage C
   ctl_type                   c_ctl_ff;
   logic                      c_neg_r_ff, c_neg_c_ff;
   logic [PROD_W-1:0]         c_prod_r_ff, c_prod_c_ff;
   logic signed [LAP_W-1:0]   c_base_ff;
   // stage D
   logic [PROD_W-1:0]         rnd_r, rnd_c;
   logic signed [LAP_W-1:0]   q_r, q_c;
   ctl_type                   d_ctl_ff;
   logic signed [LAP_W-1:0]   d_term_r_ff, d_term_c_ff, d_base_ff;
   // stage E
   logic signed [SUM_W-1:0]   sum;
   logic [SUM_W-SAMPLE_BITS:0] sum_top;
   sample_type                sat_value;
   ctl_type                   e_ctl_ff;
   sample_type                e_value_ff;

   always_comb begin
      u_s     = halo(up_value,    centre_value, in_edge.top,    mode);
      d_s     = halo(down_value,  centre_value, in_edge.bottom, mode);
      l_s     = halo(left_value,  centre_value, in_edge.left,   mode);
      r_s     = halo(right_value, centre_value, in_edge.right,  mode);
      twice_c = lap_ext(centre_value) <<< 1;
   end

   always_comb begin
      abs_r = a_lap_r_ff[LAP_W-1] ? -a_lap_r_ff : a_lap_r_ff;
      abs_c = a_lap_c_ff[LAP_W-1] ? -a_lap_c_ff : a_lap_c_ff;
   end

   always_comb begin
      rnd_r = c_prod_r_ff + PROD_W'(ROUND_HALF);
      rnd_c = c_prod_c_ff + PROD_W'(ROUND_HALF);
      q_r   = $signed({1'b0, rnd_r[PROD_W-1:FRAC_W]});
      q_c   = $signed({1'b0, rnd_c[PROD_W-1:FRAC_W]});
   end

   always_comb begin
      sum     = sum_ext(d_term_r_ff) + sum_ext(d_term_c_ff) + sum_ext(d_base_ff);
      sum_top = sum[SUM_W-1:SAMPLE_BITS-1];
      if ((&sum_top) || !(|sum_top)) begin
         sat_value = sum[SAMPLE_BITS-1:0];
      end else if (sum[SUM_W-1]) begin
         sat_value = SAT_MIN;
      end else begin
         sat_value = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
         c_ctl_ff <= '0;
         d_ctl_ff <= '0;
         e_ctl_ff <= '0;
      end else begin
         a_ctl_ff <= in_ctl;
         b_ctl_ff <= a_ctl_ff;
         c_ctl_ff <= b_ctl_ff;
         d_ctl_ff <= c_ctl_ff;
         e_ctl_ff <= d_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_lap_r_ff  <= lap_ext(u_s) - twice_c + lap_ext(d_s);
      a_lap_c_ff  <= lap_ext(l_s) - twice_c + lap_ext(r_s);
      a_base_ff   <= twice_c - lap_ext(old_value);

      b_neg_r_ff  <= a_lap_r_ff[LAP_W-1];
      b_neg_c_ff  <= a_lap_c_ff[LAP_W-1];
      b_mag_r_ff  <= abs_r[MAG_W-1:0];
      b_mag_c_ff  <= abs_c[MAG_W-1:0];
      b_base_ff   <= a_base_ff;

      c_neg_r_ff  <= b_neg_r_ff;
      c_neg_c_ff  <= b_neg_c_ff;
      c_prod_r_ff <= PROD_W'(coef_rows) * PROD_W'(b_mag_r_ff);
      c_prod_c_ff <= PROD_W'(coef_cols) * PROD_W'(b_mag_c_ff);
      c_base_ff   <= b_base_ff;

      d_term_r_ff <= c_neg_r_ff ? -q_r : q_r;
      d_term_c_ff <= c_neg_c_ff ? -q_c : q_c;
      d_base_ff   <= c_base_ff;

      e_value_ff  <= sat_value;
   end

   assign out_ctl   = e_ctl_ff;
   assign out_value = e_value_ff;

endmodule

[hdl/wes_result_fifo.sv]
// Result queue between the update pipeline and the rsp channel.
// Register-array ring buffer; uses wes_pkg.
module wes_result_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wes_pkg::result_type  push_data,
   input  logic                 pop,
   output logic                 out_valid,
   output wes_pkg::result_type  out_data
);
   import wes_pkg::*;

   result_type            entries_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CREDIT_W-1:0]   count_ff, count_in;
   logic                  do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push   ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + CREDIT_W'(push) - CREDIT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];

endmodule

[hdl/wave_equation_stencil_step.sv]
// Five-point leapfrog update of the 2-D wave equation over a streamed, padded tile.
// The tile arrives in raster order, one cell per req beat (current and old value),
// and one rsp beat follows each cell that completes an interior update, i.e. each
// cell of padded rows 2..grid_rows+1 and columns 1..grid_cols. The block takes one
// req beat per clock while req_stall is low. A result passes from req beat to rsp
// beat through the line-store read, the five-stage arithmetic (two 16x34
// multipliers) and the write into the result queue.
// Two current rows sit in one line store with two read ports, the previous old row
// in a second store; a three-tap window slides along the centre row. An 8-entry
// result queue with credit counting lets req beats keep flowing while rsp is
// stalled, until eight results are outstanding. Uses wes_pkg, wes_update,
// wes_result_fifo.
module wave_equation_stencil_step (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  wes_pkg::sample_type               req_cur_value,
   input  wes_pkg::sample_type               req_old_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output wes_pkg::sample_type               rsp_new_value,
   output logic                              rsp_last_of_frame,
   input  logic                              csr_wr_en,
   input  logic [wes_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wes_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import wes_pkg::*;

   // config registers
   logic [COEF_W-1:0]   coef_rows_ff, coef_cols_ff;
   logic [MODE_W-1:0]   boundary_mode_ff;
   logic [MASK_W-1:0]   edge_mask_ff;
   logic [DIM_W-1:0]    grid_rows_ff, grid_cols_ff;

   // position
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    rows_eff;
   logic [COL_W-1:0]    cols_eff;
   logic [ROW_W:0]      rows_p1, rows_p2, row_n;
   logic [COL_W:0]      cols_p2, col_inc;

   logic                accept, produce, is_last, pop;
   edge_type            edge_now;

   // line stores and read side
   sample_type          cur_line_ff [2*LINE_LEN];
   sample_type          old_line_ff [LINE_LEN];
   logic                bank_new;
   logic [COL_W-1:0]    right_col;
   logic [CUR_AW-1:0]   wr_addr, right_addr, up_addr;
   sample_type          rd_right_ff, rd_up_ff, rd_old_ff;
   sample_type          centre_ff, left_ff;
   logic                prev_col_zero_ff;

   ctl_type             s1_ctl_ff;
   edge_type            s1_edge_ff;
   sample_type          s1_down_ff;

   ctl_type             upd_ctl;
   sample_type          upd_value;
   result_type          push_data, head;

   logic [CREDIT_W-1:0] outstanding_ff, outstanding_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_rows_ff     <= '0;
         coef_cols_ff     <= '0;
         boundary_mode_ff <= BMODE_SUPPLIED;
         edge_mask_ff     <= '0;
         grid_rows_ff     <= DIM_W'(1);
         grid_cols_ff     <= DIM_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_COEF_ROWS:     coef_rows_ff     <= csr_wr_data[COEF_W-1:0];
            CSR_COEF_COLS:     coef_cols_ff     <= csr_wr_data[COEF_W-1:0];
            CSR_BOUNDARY_MODE: boundary_mode_ff <= csr_wr_data[MODE_W-1:0];
            CSR_EDGE_MASK:     edge_mask_ff     <= csr_wr_data[MASK_W-1:0];
            CSR_GRID_ROWS:     grid_rows_ff     <= csr_wr_data[DIM_W-1:0];
            CSR_GRID_COLS:     grid_cols_ff     <= csr_wr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (grid_rows_ff == '0) begin
         rows_eff = ROW_W'(1);
      end else if (int'(grid_rows_ff) > MAX_ROWS) begin
         rows_eff = ROW_W'(MAX_ROWS);
      end else begin
         rows_eff = ROW_W'(grid_rows_ff);
      end
      if (grid_cols_ff == '0) begin
         cols_eff = COL_W'(1);
      end else if (int'(grid_cols_ff) > MAX_COLS) begin
         cols_eff = COL_W'(MAX_COLS);
      end else begin
         cols_eff = COL_W'(grid_cols_ff);
      end
      rows_p1 = {1'b0, rows_eff} + (ROW_W+1)'(1);
      rows_p2 = {1'b0, rows_eff} + (ROW_W+1)'(2);
      cols_p2 = {1'b0, cols_eff} + (COL_W+1)'(2);
   end

   assign req_stall = (outstanding_ff >= CREDIT_W'(FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      produce  = (row_ff >= ROW_W'(2)) && ({1'b0, row_ff} <= rows_p1) &&
                 (col_ff != '0) && (col_ff <= cols_eff);
      is_last  = ({1'b0, row_ff} == rows_p1) && (col_ff == cols_eff);
      edge_now.top    = (row_ff == ROW_W'(2)) && edge_mask_ff[EDGE_TOP];
      edge_now.bottom = ({1'b0, row_ff} == rows_p1) && edge_mask_ff[EDGE_BOTTOM];
      edge_now.left   = (col_ff == COL_W'(1)) && edge_mask_ff[EDGE_LEFT];
      edge_now.right  = (col_ff == cols_eff) && edge_mask_ff[EDGE_RIGHT];
   end

   // raster position of the next beat
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      col_inc = {1'b0, col_ff} + (COL_W+1)'(1);
      row_n   = {1'b0, row_ff};
      if (accept) begin
         if (col_inc >= cols_p2) begin
            col_in = '0;
            row_n  = {1'b0, row_ff} + (ROW_W+1)'(1);
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
         if (row_n >= rows_p2) begin
            row_n  = '0;
            col_in = '0;
         end
         row_in = row_n[ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // bank row_ff[0] is being written with the incoming row; the other bank
   // holds the centre row. At column zero the up port fetches the centre
   // row's left halo instead.
   always_comb begin
      bank_new   = row_ff[0];
      right_col  = (col_ff == COL_W'(LINE_LEN - 1)) ? '0 : col_ff + COL_W'(1);
      wr_addr    = cur_addr(bank_new, col_ff);
      right_addr = cur_addr(!bank_new, right_col);
      up_addr    = (col_ff == '0) ? cur_addr(!bank_new, '0) : wr_addr;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_right_ff          <= cur_line_ff[right_addr];
         rd_up_ff             <= cur_line_ff[up_addr];
         cur_line_ff[wr_addr] <= req_cur_value;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_old_ff           <= old_line_ff[col_ff];
         old_line_ff[col_ff] <= req_old_value;
      end
   end

   // sliding window over the centre row
   always_ff @(posedge clock) begin
      if (accept) begin
         centre_ff  <= rd_right_ff;
         left_ff    <= prev_col_zero_ff ? rd_up_ff : centre_ff;
         s1_edge_ff <= edge_now;
         s1_down_ff <= req_cur_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_col_zero_ff <= 1'b0;
         s1_ctl_ff        <= '0;
      end else begin
         if (accept) begin
            prev_col_zero_ff <= (col_ff == '0);
         end
         s1_ctl_ff.valid <= accept && produce;
         s1_ctl_ff.last  <= is_last;
      end
   end

   wes_update u_update (
      .clock        (clock),
      .reset        (reset),
      .in_ctl       (s1_ctl_ff),
      .in_edge      (s1_edge_ff),
      .mode         (boundary_mode_ff),
      .coef_rows    (coef_rows_ff),
      .coef_cols    (coef_cols_ff),
      .up_value     (rd_up_ff),
      .down_value   (s1_down_ff),
      .centre_value (centre_ff),
      .left_value   (left_ff),
      .right_value  (rd_right_ff),
      .old_value    (rd_old_ff),
      .out_ctl      (upd_ctl),
      .out_value    (upd_value)
   );

   assign push_data.value = upd_value;
   assign push_data.last  = upd_ctl.last;

   wes_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (upd_ctl.valid),
      .push_data (push_data),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_data  (head)
   );

   assign rsp_new_value     = head.value;
   assign rsp_last_of_frame = head.last;

   // results in the pipeline plus results queued
   always_comb begin
      outstanding_in = outstanding_ff + CREDIT_W'(accept && produce) - CREDIT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= CREDIT_W'(FIFO_DEPTH))
      else $error("outstanding results exceed queue depth");

   a_rsp_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != '0))
      else $error("rsp beat without an outstanding result");

   a_push_counted: assert property (@(posedge clock) disable iff (reset)
      upd_ctl.valid |-> (outstanding_ff != '0))
      else $error("pipeline result not covered by a credit");

   a_issue: assert property (@(posedge clock) disable iff (reset)
      (accept && produce) |=> s1_ctl_ff.valid)
      else $error("producing beat did not enter the update pipeline");

endmodule
